// ----- hdl/npbm_pkg.sv -----
// shared constants, codes and word types of the pixel format converter
package npbm_pkg;

   // field and state widths
   localparam int SAMPLE_BITS    = 16;
   localparam int COLUMN_BITS    = 12;
   localparam int WIDTH_BITS     = 13;
   localparam int MAX_WIDTH      = 4096;
   localparam int SUM_BITS       = SAMPLE_BITS + 2;
   localparam int COUNT_BITS     = 2;
   localparam int PACK_BITS      = 8;
   localparam int PACK_IDX_BITS  = 3;

   // queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_KIND     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEST_KIND       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_MAXVALUE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEST_MAXVALUE   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH     = 3'd4;

   // pixel kinds; code 3 is the packed bitmap on the destination side
   localparam logic [1:0] KIND_BITMAP = 2'd0;
   localparam logic [1:0] KIND_GRAY   = 2'd1;
   localparam logic [1:0] KIND_COLOR  = 2'd2;
   localparam logic [1:0] KIND_PACKED = 2'd3;

   // component counts
   localparam logic [COUNT_BITS-1:0] COMPONENTS_ONE   = 2'd1;
   localparam logic [COUNT_BITS-1:0] COMPONENTS_THREE = 2'd3;

   // thresholds and packing constants
   localparam logic [SAMPLE_BITS-1:0] GRAY_THRESHOLD  = 16'd128;
   localparam logic [SUM_BITS-1:0]    COLOR_THRESHOLD = 18'd384;
   localparam logic [PACK_BITS-1:0]   PACK_MSB        = 8'h80;
   localparam logic [PACK_IDX_BITS-1:0] PACK_LAST_BIT = 3'd7;

   // divide by three: floor(x * ceil(2^20 / 3) / 2^20) is exact below 2^19
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_BITS  = 19;
   localparam logic [RECIP_BITS-1:0] RECIP_THIRD = 19'd349526;
   localparam int PRODUCT_BITS = SUM_BITS + RECIP_BITS;

   // configuration register set
   typedef struct packed {
      logic [1:0]             source_kind;
      logic [1:0]             dest_kind;
      logic [SAMPLE_BITS-1:0] source_maxvalue;
      logic [SAMPLE_BITS-1:0] dest_maxvalue;
      logic [WIDTH_BITS-1:0]  image_width;
   } cfg_type;

   // classified word handed from front to back
   typedef struct packed {
      logic                   need_div;
      logic [SUM_BITS-1:0]    first;
      logic [SAMPLE_BITS-1:0] second;
      logic [SAMPLE_BITS-1:0] third;
      logic [COUNT_BITS-1:0]  count;
      logic                   row_end;
      logic                   image_end;
   } word_type;

   // queue status seen by both sides
   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

endpackage

// ----- hdl/npbm_front.sv -----
// front end: accepts pixels, tracks columns, packs bitmaps and classifies each word
module npbm_front
   import npbm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample_first,
   input  logic [SAMPLE_BITS-1:0] req_sample_second,
   input  logic [SAMPLE_BITS-1:0] req_sample_third,
   input  logic                   req_last_pixel,
   input  queue_status_type       queue_status,
   output logic                   push,
   output word_type               push_word
);

   logic [COLUMN_BITS-1:0]   column_ff, column_in;
   logic [PACK_BITS-1:0]     pack_ff, pack_in;
   logic [PACK_IDX_BITS-1:0] bit_count_ff, bit_count_in;

   logic                     accept;
   logic [1:0]               src;
   logic [WIDTH_BITS-1:0]    width_eff;
   logic [WIDTH_BITS-1:0]    column_plus;
   logic                     row_end;
   logic [SUM_BITS-1:0]      sum;
   logic [SAMPLE_BITS-1:0]   half_max;
   logic [SUM_BITS-1:0]      triple_max;
   logic [SUM_BITS-1:0]      triple_half;
   logic                     black;
   logic [PACK_BITS-1:0]     pack_merged;
   logic                     pack_emit;
   logic [SAMPLE_BITS-1:0]   bitmap_value;
   word_type                 word;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !req_stall;

   // effective source kind and row width
   always_comb begin
      src = (cfg.source_kind == KIND_PACKED) ? KIND_GRAY : cfg.source_kind;
      if (cfg.image_width == '0) begin
         width_eff = WIDTH_BITS'(1);
      end else if (cfg.image_width > WIDTH_BITS'(MAX_WIDTH)) begin
         width_eff = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         width_eff = cfg.image_width;
      end
   end

   // row end detection
   assign column_plus = {1'b0, column_ff} + WIDTH_BITS'(1);
   assign row_end     = req_last_pixel || (column_plus >= width_eff);

   // component sum and packed thresholds
   assign sum = SUM_BITS'(req_sample_first) + SUM_BITS'(req_sample_second)
              + SUM_BITS'(req_sample_third);
   assign half_max    = cfg.source_maxvalue >> 1;
   assign triple_max  = SUM_BITS'(cfg.source_maxvalue)
                      + SUM_BITS'({cfg.source_maxvalue, 1'b0});
   assign triple_half = triple_max >> 1;

   // black decision for the packed bitmap
   always_comb begin
      case (src)
         KIND_BITMAP: black = (req_sample_first != '0);
         KIND_COLOR:  black = (sum <= triple_half);
         default:     black = (req_sample_first <= half_max);
      endcase
   end

   assign pack_merged = black ? (pack_ff | (PACK_MSB >> bit_count_ff)) : pack_ff;
   assign pack_emit   = (bit_count_ff == PACK_LAST_BIT) || row_end;

   // bitmap scaled up: black is zero, white is the destination maximum
   assign bitmap_value = (req_sample_first != '0) ? '0 : cfg.dest_maxvalue;

   // word classification
   always_comb begin
      word           = '0;
      word.count     = COMPONENTS_ONE;
      word.row_end   = row_end;
      word.image_end = req_last_pixel;
      if (cfg.dest_kind == KIND_PACKED) begin
         word.first = SUM_BITS'(pack_merged);
      end else if (src == cfg.dest_kind) begin
         word.first = SUM_BITS'(req_sample_first);
         if (src == KIND_COLOR) begin
            word.second = req_sample_second;
            word.third  = req_sample_third;
            word.count  = COMPONENTS_THREE;
         end
      end else begin
         case (src)
            KIND_BITMAP: begin
               word.first = SUM_BITS'(bitmap_value);
               if (cfg.dest_kind == KIND_COLOR) begin
                  word.second = bitmap_value;
                  word.third  = bitmap_value;
                  word.count  = COMPONENTS_THREE;
               end
            end
            KIND_GRAY: begin
               if (cfg.dest_kind == KIND_BITMAP) begin
                  word.first = (req_sample_first >= GRAY_THRESHOLD) ? '0 : SUM_BITS'(1);
               end else begin
                  word.first  = SUM_BITS'(req_sample_first);
                  word.second = req_sample_first;
                  word.third  = req_sample_first;
                  word.count  = COMPONENTS_THREE;
               end
            end
            default: begin
               if (cfg.dest_kind == KIND_BITMAP) begin
                  word.first = (sum >= COLOR_THRESHOLD) ? '0 : SUM_BITS'(1);
               end else begin
                  word.first    = sum;
                  word.need_div = 1'b1;
               end
            end
         endcase
      end
   end

   // queue push: packed mode only when a byte closes
   assign push      = accept && ((cfg.dest_kind != KIND_PACKED) || pack_emit);
   assign push_word = word;

   // column and packing state
   always_comb begin
      column_in    = column_ff;
      pack_in      = pack_ff;
      bit_count_in = bit_count_ff;
      if (accept) begin
         column_in = row_end ? '0 : column_plus[COLUMN_BITS-1:0];
         if (cfg.dest_kind == KIND_PACKED) begin
            if (pack_emit) begin
               pack_in      = '0;
               bit_count_in = '0;
            end else begin
               pack_in      = pack_merged;
               bit_count_in = bit_count_ff + PACK_IDX_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         pack_ff      <= '0;
         bit_count_ff <= '0;
      end else begin
         column_ff    <= column_in;
         pack_ff      <= pack_in;
         bit_count_ff <= bit_count_in;
      end
   end

endmodule

// ----- hdl/npbm_queue.sv -----
// short word queue between the front and back ends
module npbm_queue
   import npbm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  word_type         push_word,
   input  logic             pop,
   output word_type         head_word,
   output queue_status_type status
);

   word_type                  entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign head_word        = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ----- hdl/npbm_back.sv -----
// back end: divides colour sums by three and drives the result register
module npbm_back
   import npbm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  queue_status_type       queue_status,
   input  word_type               head_word,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SAMPLE_BITS-1:0] rsp_value_first,
   output logic [SAMPLE_BITS-1:0] rsp_value_second,
   output logic [SAMPLE_BITS-1:0] rsp_value_third,
   output logic [COUNT_BITS-1:0]  rsp_component_count,
   output logic                   rsp_row_end,
   output logic                   rsp_image_end
);

   logic                    s1_valid_ff, s1_valid_in;
   word_type                s1_word_ff, s1_word_in;
   logic                    out_valid_ff, out_valid_in;
   word_type                out_word_ff;

   logic                    out_load;
   logic                    s1_load;
   logic [PRODUCT_BITS-1:0] product;

   // pipeline flow
   assign out_load = !out_valid_ff || !rsp_stall;
   assign s1_load  = !s1_valid_ff || out_load;
   assign pop      = queue_status.not_empty && s1_load;

   // divide by three through the reciprocal
   assign product = PRODUCT_BITS'(head_word.first) * PRODUCT_BITS'(RECIP_THIRD);

   always_comb begin
      s1_word_in = head_word;
      if (head_word.need_div) begin
         s1_word_in.first = SUM_BITS'(product[RECIP_SHIFT+SAMPLE_BITS-1:RECIP_SHIFT]);
      end
      s1_valid_in  = pop ? 1'b1 : (out_load ? 1'b0 : s1_valid_ff);
      out_valid_in = out_load ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_word_ff <= s1_word_in;
      end
      if (out_load && s1_valid_ff) begin
         out_word_ff <= s1_word_ff;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_value_first     = out_word_ff.first[SAMPLE_BITS-1:0];
   assign rsp_value_second    = out_word_ff.second;
   assign rsp_value_third     = out_word_ff.third;
   assign rsp_component_count = out_word_ff.count;
   assign rsp_row_end         = out_word_ff.row_end;
   assign rsp_image_end       = out_word_ff.image_end;

endmodule

// ----- hdl/netpbm_pixel_format_converter.sv -----
// top level of the pixel format converter: configuration registers and wiring
// a taken pixel goes through a queue entry, the divide stage and the result register to rsp_valid
// throughput: one pixel per clock while req_stall is low; a four-word queue lets front and back stall apart
// packed bitmap mode emits one word per eight pixels or at row and image end
// reset: synchronous, empties queue and pipeline, clears column and packing state,
// and loads configuration defaults (gray to gray, maxvalues 255, width 1)
module netpbm_pixel_format_converter
   import npbm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SAMPLE_BITS-1:0]    req_sample_first,
   input  logic [SAMPLE_BITS-1:0]    req_sample_second,
   input  logic [SAMPLE_BITS-1:0]    req_sample_third,
   input  logic                      req_last_pixel,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [SAMPLE_BITS-1:0]    rsp_value_first,
   output logic [SAMPLE_BITS-1:0]    rsp_value_second,
   output logic [SAMPLE_BITS-1:0]    rsp_value_third,
   output logic [COUNT_BITS-1:0]     rsp_component_count,
   output logic                      rsp_row_end,
   output logic                      rsp_image_end
);

   cfg_type          cfg_ff, cfg_in;
   queue_status_type queue_status;
   logic             push;
   logic             pop;
   word_type         push_word;
   word_type         head_word;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SOURCE_KIND:     cfg_in.source_kind     = csr_write_data[1:0];
            CSR_DEST_KIND:       cfg_in.dest_kind       = csr_write_data[1:0];
            CSR_SOURCE_MAXVALUE: cfg_in.source_maxvalue = csr_write_data;
            CSR_DEST_MAXVALUE:   cfg_in.dest_maxvalue   = csr_write_data;
            CSR_IMAGE_WIDTH:     cfg_in.image_width     = csr_write_data[WIDTH_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_kind     <= KIND_GRAY;
         cfg_ff.dest_kind       <= KIND_GRAY;
         cfg_ff.source_maxvalue <= SAMPLE_BITS'(255);
         cfg_ff.dest_maxvalue   <= SAMPLE_BITS'(255);
         cfg_ff.image_width     <= WIDTH_BITS'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end
   npbm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_first  (req_sample_first),
      .req_sample_second (req_sample_second),
      .req_sample_third  (req_sample_third),
      .req_last_pixel    (req_last_pixel),
      .queue_status      (queue_status),
      .push              (push),
      .push_word         (push_word)
   );

   // decoupling queue
   npbm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .head_word (head_word),
      .status    (queue_status)
   );

   // back end
   npbm_back u_back (
      .clock               (clock),
      .reset               (reset),
      .queue_status        (queue_status),
      .head_word           (head_word),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_value_first     (rsp_value_first),
      .rsp_value_second    (rsp_value_second),
      .rsp_value_third     (rsp_value_third),
      .rsp_component_count (rsp_component_count),
      .rsp_row_end         (rsp_row_end),
      .rsp_image_end       (rsp_image_end)
   );

   // checks
   a_no_word_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word valid right after reset");

   a_image_end_closes_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_image_end) |-> rsp_row_end)
      else $error("image end without row end");

   a_count_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_component_count == COMPONENTS_ONE ||
                     rsp_component_count == COMPONENTS_THREE))
      else $error("illegal component count");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      queue_status.full |-> !push)
      else $error("queue written while full");

endmodule

// ----- bench/tb_top.sv -----
// self-checking testbench of the pixel format converter with its scoreboard class
`timescale 1ns / 100ps

module tb_top;
   import npbm_pkg::*;

   localparam int CLOCK_HALF    = 10;
   localparam int RANDOM_PIXELS = 600;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 80;
   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_PHASE    = 3;

   // one input pixel and one result word as seen on the ports
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] first;
      logic [SAMPLE_BITS-1:0] second;
      logic [SAMPLE_BITS-1:0] third;
      logic                   last;
   } pixel_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] first;
      logic [SAMPLE_BITS-1:0] second;
      logic [SAMPLE_BITS-1:0] third;
      logic [COUNT_BITS-1:0]  count;
      logic                   row_end;
      logic                   image_end;
   } result_type;

   // converter predictor: own copy of registers, row and packing state
   class conversion_scoreboard;
      cfg_type                  cfg;
      logic [COLUMN_BITS-1:0]   column;
      logic [PACK_BITS-1:0]     pack_byte;
      logic [PACK_IDX_BITS-1:0] pack_count;
      result_type               expected_words[$];
      int                       failures;

      function new();
         cfg.source_kind     = KIND_GRAY;
         cfg.dest_kind       = KIND_GRAY;
         cfg.source_maxvalue = 16'd255;
         cfg.dest_maxvalue   = 16'd255;
         cfg.image_width     = 13'd1;
         column     = '0;
         pack_byte  = '0;
         pack_count = '0;
         failures   = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_SOURCE_KIND:     cfg.source_kind     = data[1:0];
            CSR_DEST_KIND:       cfg.dest_kind       = data[1:0];
            CSR_SOURCE_MAXVALUE: cfg.source_maxvalue = data;
            CSR_DEST_MAXVALUE:   cfg.dest_maxvalue   = data;
            CSR_IMAGE_WIDTH:     cfg.image_width     = data[WIDTH_BITS-1:0];
            default: ;
         endcase
      endfunction

      // work out the word an accepted pixel causes, if any
      function void note_pixel(pixel_type px);
         logic [1:0]  src;
         int unsigned row_len;
         int unsigned sum;
         int unsigned white;
         bit          row_end;
         bit          black;
         result_type  word;
         src = (cfg.source_kind == KIND_PACKED) ? KIND_GRAY : cfg.source_kind;
         row_len = cfg.image_width;
         if (row_len == 0) row_len = 1;
         else if (row_len > MAX_WIDTH) row_len = MAX_WIDTH;
         sum = px.first + px.second + px.third;
         row_end = px.last || (column + 32'd1 >= row_len);
         column = row_end ? '0 : column + 1'b1;

         word = '0;
         word.count = COMPONENTS_ONE;
         word.row_end = row_end;
         word.image_end = px.last;

         // packed bitmap: gather msb first, emit on full byte or row end
         if (cfg.dest_kind == KIND_PACKED) begin
            case (src)
               KIND_BITMAP: black = (px.first != 0);
               KIND_GRAY:   black = (px.first <= cfg.source_maxvalue / 2);
               default:     black = (sum <= (cfg.source_maxvalue * 3) / 2);
            endcase
            if (black) pack_byte = pack_byte | (PACK_MSB >> pack_count);
            if (pack_count == PACK_LAST_BIT || row_end) begin
               word.first = 16'(pack_byte);
               expected_words.push_back(word);
               pack_byte = '0;
               pack_count = '0;
            end else begin
               pack_count = pack_count + 1'b1;
            end
            return;
         end

         if (src == cfg.dest_kind) begin
            word.first = px.first;
            if (src == KIND_COLOR) begin
               word.second = px.second;
               word.third = px.third;
               word.count = COMPONENTS_THREE;
            end
         end else if (src == KIND_BITMAP) begin
            // any nonzero bit is black, black maps to zero
            white = (px.first != 0) ? 0 : cfg.dest_maxvalue;
            word.first = 16'(white);
            if (cfg.dest_kind == KIND_COLOR) begin
               word.second = 16'(white);
               word.third = 16'(white);
               word.count = COMPONENTS_THREE;
            end
         end else if (src == KIND_GRAY) begin
            if (cfg.dest_kind == KIND_BITMAP) begin
               word.first = (px.first >= GRAY_THRESHOLD) ? 16'd0 : 16'd1;
            end else begin
               word.first = px.first;
               word.second = px.first;
               word.third = px.first;
               word.count = COMPONENTS_THREE;
            end
         end else begin
            if (cfg.dest_kind == KIND_BITMAP) word.first = (sum >= COLOR_THRESHOLD) ? 16'd0 : 16'd1;
            else word.first = 16'(sum / 3);
         end
         expected_words.push_back(word);
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            failures++;
         end
      endfunction

      // match an accepted word against the oldest prediction
      function void check_word(result_type got);
         result_type want;
         if (expected_words.size() == 0) begin
            $error("word with none expected: value_first %0d", got.first);
            failures++;
            return;
         end
         want = expected_words.pop_front();
         compare("value_first", want.first, got.first);
         compare("value_second", want.second, got.second);
         compare("value_third", want.third, got.third);
         compare("component_count", want.count, got.count);
         compare("row_end", want.row_end, got.row_end);
         compare("image_end", want.image_end, got.image_end);
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;
   logic                      req_valid;
   logic                      req_stall;
   logic [SAMPLE_BITS-1:0]    req_sample_first;
   logic [SAMPLE_BITS-1:0]    req_sample_second;
   logic [SAMPLE_BITS-1:0]    req_sample_third;
   logic                      req_last_pixel;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [SAMPLE_BITS-1:0]    rsp_value_first;
   logic [SAMPLE_BITS-1:0]    rsp_value_second;
   logic [SAMPLE_BITS-1:0]    rsp_value_third;
   logic [COUNT_BITS-1:0]     rsp_component_count;
   logic                      rsp_row_end;
   logic                      rsp_image_end;
   result_type                rsp_word;

   conversion_scoreboard sb;
   int burst_left = 0;
   int idle_cycles = 0;
   int hold_count = 0;

   netpbm_pixel_format_converter uut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample_first    (req_sample_first),
      .req_sample_second   (req_sample_second),
      .req_sample_third    (req_sample_third),
      .req_last_pixel      (req_last_pixel),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_value_first     (rsp_value_first),
      .rsp_value_second    (rsp_value_second),
      .rsp_value_third     (rsp_value_third),
      .rsp_component_count (rsp_component_count),
      .rsp_row_end         (rsp_row_end),
      .rsp_image_end       (rsp_image_end)
   );

   assign rsp_word = {rsp_value_first, rsp_value_second, rsp_value_third,
                      rsp_component_count, rsp_row_end, rsp_image_end};

   always begin
      clock = 1'b0;
      #CLOCK_HALF;
      clock = 1'b1;
      #CLOCK_HALF;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_word);
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver stall pattern, with a long hold-off on request
   initial begin
      int mode;
      int span;
      int holds_done;
      holds_done = 0;
      forever begin
         if (hold_count != holds_done) begin
            holds_done = hold_count;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 40);
            repeat (span) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= 1'($urandom_range(0, 1));
                  default: rsp_stall <= ($urandom_range(0, 7) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      sb.set_reg(index, data);
   endtask

   task automatic configure(logic [15:0] src, logic [15:0] dst, logic [15:0] src_max,
                            logic [15:0] dst_max, logic [15:0] width);
      write_reg(CSR_SOURCE_KIND, src);
      write_reg(CSR_DEST_KIND, dst);
      write_reg(CSR_SOURCE_MAXVALUE, src_max);
      write_reg(CSR_DEST_MAXVALUE, dst_max);
      write_reg(CSR_IMAGE_WIDTH, width);
      csr_write_enable <= 1'b0;
   endtask

   // offer one pixel in bursts with random gaps, hold it until taken
   task automatic send_pixel(pixel_type px);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_sample_first <= px.first;
      req_sample_second <= px.second;
      req_sample_third <= px.third;
      req_last_pixel <= px.last;
      do @(posedge clock); while (req_stall);
      sb.note_pixel(px);
   endtask

   // drain all words and let the pipeline settle before a register write
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] random_maxvalue();
      case ($urandom_range(0, 3))
         0: return 16'd1;
         1: return 16'hFFFF;
         2: return 16'd255;
         default: return 16'($urandom_range(1, 65535));
      endcase
   endfunction

   task automatic random_config(bit force_color);
      logic [15:0] data;
      if ($urandom_range(0, 3) != 0) begin
         data = 16'($urandom);
         if ($urandom_range(0, 1)) data[15:2] = '0;
         write_reg(CSR_SOURCE_KIND, data);
      end
      if (force_color || $urandom_range(0, 3) != 0) begin
         data = 16'($urandom);
         if ($urandom_range(0, 1)) data[15:2] = '0;
         if (force_color) data[1:0] = KIND_COLOR;
         write_reg(CSR_DEST_KIND, data);
      end
      if ($urandom_range(0, 3) != 0) write_reg(CSR_SOURCE_MAXVALUE, random_maxvalue());
      if ($urandom_range(0, 3) != 0) write_reg(CSR_DEST_MAXVALUE, random_maxvalue());
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 9))
            0: data = 16'd0;
            1: data = $urandom_range(0, 1) ? 16'd4096 : 16'($urandom_range(4095, 8191));
            2: data = 16'($urandom_range(13, 40));
            default: data = 16'($urandom_range(1, 12));
         endcase
         data[15:13] = 3'($urandom);
         write_reg(CSR_IMAGE_WIDTH, data);
      end
      csr_write_enable <= 1'b0;
   endtask

   // random pixel, often close to the threshold of the current conversion
   function automatic pixel_type random_pixel(bit last_flag);
      pixel_type   px;
      logic [1:0]  src;
      int unsigned threshold;
      int unsigned target;
      int          mode;
      bit          packed_dest;
      src = (sb.cfg.source_kind == KIND_PACKED) ? KIND_GRAY : sb.cfg.source_kind;
      packed_dest = (sb.cfg.dest_kind == KIND_PACKED);
      px.first = 16'($urandom);
      px.second = 16'($urandom);
      px.third = 16'($urandom);
      px.last = last_flag;
      mode = $urandom_range(0, 3);
      case (src)
         KIND_BITMAP: begin
            if (mode != 0) px.first = 16'($urandom_range(0, 1));
         end
         KIND_GRAY: begin
            threshold = packed_dest ? sb.cfg.source_maxvalue / 2 : GRAY_THRESHOLD;
            target = threshold + $urandom_range(0, 4);
            target = (target < 2) ? 0 : target - 2;
            if (mode == 1) px.first = 16'(target);
            else if (mode == 2) px.first = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else if (mode == 3) px.first = 16'($urandom_range(0, sb.cfg.source_maxvalue));
         end
         default: begin
            threshold = packed_dest ? (sb.cfg.source_maxvalue * 3) / 2 : COLOR_THRESHOLD;
            target = threshold + $urandom_range(0, 4);
            target = (target < 2) ? 0 : target - 2;
            if (mode == 1) begin
               px.first = 16'(target / 3);
               px.second = 16'(target / 3);
               px.third = 16'(target - 2 * (target / 3));
            end else if (mode == 2) begin
               px.first = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               px.second = px.first;
               px.third = px.first;
            end else if (mode == 3) begin
               px.first = 16'($urandom_range(0, sb.cfg.source_maxvalue));
               px.second = 16'($urandom_range(0, sb.cfg.source_maxvalue));
               px.third = 16'($urandom_range(0, sb.cfg.source_maxvalue));
            end
         end
      endcase
      return px;
   endfunction

   // stimulus
   initial begin
      int          sent;
      int          phase;
      int          count;
      int          row_len;
      bit          image_mode;
      int unsigned target;
      sb = new();
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      req_valid <= 1'b0;
      req_sample_first <= '0;
      req_sample_second <= '0;
      req_sample_third <= '0;
      req_last_pixel <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // gray copy under reset defaults, extremes of the samples
      send_pixel('{16'h0000, 16'h0000, 16'h0000, 1'b0});
      send_pixel('{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});

      // colour to gray, width zero acting as one
      wait_idle();
      configure(KIND_COLOR, KIND_GRAY, 16'd255, 16'd255, 16'd0);
      send_pixel('{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0});
      send_pixel('{16'h0001, 16'h0001, 16'h0000, 1'b0});

      // bitmap to colour, non 0/1 bit, width above the maximum
      wait_idle();
      configure(KIND_BITMAP, KIND_COLOR, 16'd255, 16'hFFFF, 16'd8191);
      send_pixel('{16'h0002, 16'($urandom), 16'($urandom), 1'b0});
      send_pixel('{16'h0000, 16'($urandom), 16'($urandom), 1'b0});
      send_pixel('{16'h0001, 16'($urandom), 16'($urandom), 1'b1});

      // undefined source kind as gray, threshold to bitmap
      wait_idle();
      configure(KIND_PACKED, KIND_BITMAP, 16'd1, 16'd1, 16'd2);
      send_pixel('{16'd127, 16'($urandom), 16'($urandom), 1'b0});
      send_pixel('{16'd128, 16'($urandom), 16'($urandom), 1'b0});

      // colour threshold to bitmap, sum just below and at the limit, image closed
      wait_idle();
      configure(KIND_COLOR, KIND_BITMAP, 16'd255, 16'd255, 16'd3);
      send_pixel('{16'd128, 16'd128, 16'd127, 1'b0});
      send_pixel('{16'd128, 16'd128, 16'd128, 1'b1});

      // colour packed: a full byte in mid row, then a padded flush at row end
      wait_idle();
      configure(KIND_COLOR, KIND_PACKED, 16'hFFFF, 16'd255, 16'd10);
      for (int i = 0; i < 10; i++) begin
         target = (i % 2 == 0) ? 98302 - i : 98303 + i;
         send_pixel('{16'(target / 3), 16'(target / 3), 16'(target - 2 * (target / 3)), 1'b0});
      end

      // random phases of random settings
      sent = 0;
      phase = 0;
      while (sent < RANDOM_PIXELS) begin
         wait_idle();
         random_config(phase == HOLD_PHASE);
         row_len = sb.cfg.image_width;
         if (row_len == 0) row_len = 1;
         else if (row_len > MAX_WIDTH) row_len = MAX_WIDTH;
         image_mode = (phase != HOLD_PHASE) && (row_len <= 16) && $urandom_range(0, 1);
         if (phase == HOLD_PHASE) begin
            count = 100;
            hold_count++;
         end else if (image_mode) begin
            count = row_len * $urandom_range(1, 4);
         end else begin
            count = $urandom_range(8, 50);
         end
         for (int i = 0; i < count; i++) begin
            if (image_mode) send_pixel(random_pixel(i == count - 1));
            else send_pixel(random_pixel($urandom_range(0, 15) == 0));
         end
         sent += count;
         phase++;
      end

      wait_idle();
      if (sb.failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
